// File: src/spsa_pkg.sv
package spsa_pkg;

  // field widths
  localparam int POS_W     = 16;
  localparam int CH_W      = 14;
  localparam int SUMP_W    = 26;
  localparam int SUMC_W    = 24;
  localparam int CNT_W     = 16;
  localparam int DVD_W     = 32;
  localparam int DVS_W     = 16;
  localparam int SEED_W    = 2 * POS_W + 3 * CH_W;
  localparam int SUM_W     = 2 * SUMP_W + 3 * SUMC_W + CNT_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // item modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ASSIGN = 2'd1;
  localparam logic [1:0] MODE_ACCUM  = 2'd2;
  localparam logic [1:0] MODE_UPDATE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] seed_index;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] pixel_l;
    logic [7:0] pixel_a;
    logic [7:0] pixel_b;
    logic [4:0] cell_col;
    logic [4:0] cell_row;
  } in_t;

  typedef struct packed {
    logic [9:0]       label;
    logic [1:0]       status;
    logic [POS_W-1:0] seed_x_out;
    logic [POS_W-1:0] seed_y_out;
    logic [CH_W-1:0]  seed_l_out;
    logic [CH_W-1:0]  seed_a_out;
    logic [CH_W-1:0]  seed_b_out;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: src/spsa_ram.sv
module spsa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/spsa_div.sv
module spsa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  spsa_pkg::div_req_t req,
  output spsa_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(spsa_pkg::DVD_W);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [spsa_pkg::DVD_W-1:0]  quo_r, quo_nxt;
  logic [spsa_pkg::DVS_W-1:0]  rem_r, rem_nxt;
  logic [spsa_pkg::DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [spsa_pkg::DVS_W:0]    sh;
  logic [spsa_pkg::DVS_W:0]    diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    sh       = {rem_r, quo_r[spsa_pkg::DVD_W-1]};
    diff     = sh - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = diff[spsa_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[spsa_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[spsa_pkg::DVS_W-1:0];
        quo_nxt = {quo_r[spsa_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(spsa_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: src/superpixel_seed_assign_update.sv
// channel | ports                            | item
// in      | in_valid, in_ready, in_data      | mode, seed index, pixel, cell
// out     | out_valid, out_ready, out_data   | label, status, updated seed
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, always ready
//
// assign visits each candidate cell in turn, paced by the single shared multiplier
// and the one read port of the seed memory.
// update computes five means through one bit-serial divider.
// after reset a clearing pass zeroes all MAX_SEEDS entries of the sum memory;
// no item is taken until it ends. a result waiting at out holds the block
// at its end of the next item only.
module superpixel_seed_assign_update #(
  parameter int MAX_SEEDS     = 1024,
  parameter int NEIGHBOURHOOD = 9
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  spsa_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output spsa_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spsa_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int AW   = $clog2(MAX_SEEDS);
  localparam int IW   = ((AW + 1) > 13) ? (AW + 1) : 13;
  localparam int RAD  = (NEIGHBOURHOOD >= 25) ? 2 : 1;
  localparam logic [2:0] LASTC = 3'(2 * RAD);
  localparam int PW   = spsa_pkg::POS_W;
  localparam int CHW  = spsa_pkg::CH_W;
  localparam int SPW  = spsa_pkg::SUMP_W;
  localparam int SCW  = spsa_pkg::SUMC_W;
  localparam int CNW  = spsa_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CAND, S_SQ, S_TOT, S_CMP, S_ACC, S_MEAN, S_DGO, S_DWT, S_MWR, S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  spsa_pkg::in_t      req_r, req_nxt;
  spsa_pkg::out_t     res_r, res_nxt;
  spsa_pkg::out_t     out_r, out_nxt;
  logic               outv_r, outv_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [5:0]         cols_r, cols_nxt;
  logic [5:0]         rows_r, rows_nxt;
  logic [15:0]        wgt_r, wgt_nxt;
  logic [2:0]         dr_r, dr_nxt;
  logic [2:0]         dc_r, dc_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [29:0]        dlab_r, dlab_nxt;
  logic [32:0]        dxy_r, dxy_nxt;
  logic [49:0]        tot_r, tot_nxt;
  logic [49:0]        best_r, best_nxt;
  logic               found_r, found_nxt;
  logic [IW-1:0]      bidx_r, bidx_nxt;
  logic [IW-1:0]      cidx_r, cidx_nxt;
  logic [2:0]         dk_r, dk_nxt;
  logic [PW-1:0]      mq_r [5];
  logic [PW-1:0]      mq_nxt [5];

  // memories
  logic                         sd_we, sd_re, sm_we, sm_re;
  logic [AW-1:0]                sd_wa, sd_ra, sm_wa, sm_ra;
  logic [spsa_pkg::SEED_W-1:0]  sd_wd, sd_q;
  logic [spsa_pkg::SUM_W-1:0]   sm_wd, sm_q;

  spsa_ram #(.W(spsa_pkg::SEED_W), .D(MAX_SEEDS)) u_seed_ram (
    .clk(clk), .we(sd_we), .waddr(sd_wa), .wdata(sd_wd),
    .re(sd_re), .raddr(sd_ra), .rdata(sd_q)
  );

  spsa_ram #(.W(spsa_pkg::SUM_W), .D(MAX_SEEDS)) u_sum_ram (
    .clk(clk), .we(sm_we), .waddr(sm_wa), .wdata(sm_wd),
    .re(sm_re), .raddr(sm_ra), .rdata(sm_q)
  );

  spsa_pkg::div_req_t div_req;
  spsa_pkg::div_rsp_t div_rsp;

  spsa_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // seed and sum fields
  logic [PW-1:0]  sd_x, sd_y;
  logic [CHW-1:0] sd_l, sd_a, sd_b;
  logic [SPW-1:0] sm_x, sm_y;
  logic [SCW-1:0] sm_l, sm_a, sm_b;
  logic [CNW-1:0] sm_cnt;

  assign {sd_x, sd_y, sd_l, sd_a, sd_b} = sd_q;
  assign {sm_x, sm_y, sm_l, sm_a, sm_b, sm_cnt} = sm_q;

  // shared multiplier
  logic [32:0] mul_a;
  logic [15:0] mul_b;
  logic [48:0] mul_p;
  logic [15:0] op_pix, op_seed, op_d;

  assign mul_p = 49'(mul_a) * 49'(mul_b);

  always_comb begin
    case (step_r)
      3'd0:    begin op_pix = 16'({req_r.pixel_l, 6'b0}); op_seed = 16'(sd_l); end
      3'd1:    begin op_pix = 16'({req_r.pixel_a, 6'b0}); op_seed = 16'(sd_a); end
      3'd2:    begin op_pix = 16'({req_r.pixel_b, 6'b0}); op_seed = 16'(sd_b); end
      3'd3:    begin op_pix = {req_r.pixel_x, 6'b0}; op_seed = sd_x; end
      default: begin op_pix = {req_r.pixel_y, 6'b0}; op_seed = sd_y; end
    endcase
    op_d = (op_pix >= op_seed) ? (op_pix - op_seed) : (op_seed - op_pix);
    if (state_r == S_TOT) begin
      mul_a = dxy_r;
      mul_b = wgt_r;
    end else begin
      mul_a = 33'(op_d);
      mul_b = op_d;
    end
  end

  // candidate cell
  logic [7:0]    r_s, c_s;
  logic [11:0]   cprod;
  logic [IW-1:0] cidx;
  logic          cvalid, clast;

  always_comb begin
    r_s    = 8'(req_r.cell_row) + 8'(dr_r) - 8'(RAD);
    c_s    = 8'(req_r.cell_col) + 8'(dc_r) - 8'(RAD);
    cprod  = 12'(r_s[5:0]) * 12'(cols_r);
    cidx   = IW'(cprod) + IW'(c_s[5:0]);
    cvalid = !r_s[7] && (r_s < 8'(rows_r)) && !c_s[7] && (c_s < 8'(cols_r))
             && (cidx < IW'(MAX_SEEDS));
    clast  = (dr_r == LASTC) && (dc_r == LASTC);
  end

  // divider operand
  logic [spsa_pkg::DVD_W-1:0] dvd;

  always_comb begin
    case (dk_r)
      3'd0:    dvd = {sm_x, 6'b0};
      3'd1:    dvd = {sm_y, 6'b0};
      3'd2:    dvd = 32'({sm_l, 6'b0});
      3'd3:    dvd = 32'({sm_a, 6'b0});
      default: dvd = 32'({sm_b, 6'b0});
    endcase
    div_req.start    = (state_r == S_DGO);
    div_req.dividend = dvd + 32'(sm_cnt >> 1);
    div_req.divisor  = sm_cnt;
  end

  logic in_acc, in_rng, cmp_win, fin_go;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    outv_nxt  = outv_r;
    clr_nxt   = clr_r;
    cols_nxt  = cols_r;
    rows_nxt  = rows_r;
    wgt_nxt   = wgt_r;
    dr_nxt    = dr_r;
    dc_nxt    = dc_r;
    step_nxt  = step_r;
    dlab_nxt  = dlab_r;
    dxy_nxt   = dxy_r;
    tot_nxt   = tot_r;
    best_nxt  = best_r;
    found_nxt = found_r;
    bidx_nxt  = bidx_r;
    cidx_nxt  = cidx_r;
    dk_nxt    = dk_r;
    for (int i = 0; i < 5; i++) begin
      mq_nxt[i] = mq_r[i];
    end
    sd_we = 1'b0;
    sd_re = 1'b0;
    sd_wa = in_data.seed_index[AW-1:0];
    sd_ra = in_data.seed_index[AW-1:0];
    sd_wd = {{in_data.pixel_x, 6'b0}, {in_data.pixel_y, 6'b0}, {in_data.pixel_l, 6'b0},
             {in_data.pixel_a, 6'b0}, {in_data.pixel_b, 6'b0}};
    sm_we = 1'b0;
    sm_re = 1'b0;
    sm_wa = in_data.seed_index[AW-1:0];
    sm_ra = in_data.seed_index[AW-1:0];
    sm_wd = '0;
    in_acc  = in_valid && (state_r == S_IDLE);
    in_rng  = IW'(in_data.seed_index) < IW'(MAX_SEEDS);
    cmp_win = !found_r || (tot_r < best_r);
    fin_go  = !outv_r || out_ready;

    // output register
    if (outv_r && out_ready) begin
      outv_nxt = 1'b0;
    end

    // configuration writes
    if (cfg_valid) begin
      unique case (cfg_index)
        spsa_pkg::CFG_COLS:   cols_nxt = cfg_data[5:0];
        spsa_pkg::CFG_ROWS:   rows_nxt = cfg_data[5:0];
        spsa_pkg::CFG_WEIGHT: wgt_nxt  = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLR: begin
        sm_we   = 1'b1;
        sm_wa   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(MAX_SEEDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_data;
          res_nxt = '0;
          res_nxt.label = in_data.seed_index;
          dr_nxt    = '0;
          dc_nxt    = '0;
          found_nxt = 1'b0;
          dk_nxt    = '0;
          if (in_data.mode == spsa_pkg::MODE_ASSIGN) begin
            state_nxt = S_CAND;
          end else if (!in_rng) begin
            res_nxt.status = spsa_pkg::ST_NONE;
            state_nxt = S_FIN;
          end else if (in_data.mode == spsa_pkg::MODE_LOAD) begin
            sd_we = 1'b1;
            sm_we = 1'b1;
            state_nxt = S_FIN;
          end else begin
            sm_re = 1'b1;
            sd_re = 1'b1;
            state_nxt = (in_data.mode == spsa_pkg::MODE_ACCUM) ? S_ACC : S_MEAN;
          end
        end
      end
      S_CAND: begin
        sd_ra = cidx[AW-1:0];
        if (cvalid) begin
          sd_re     = 1'b1;
          cidx_nxt  = cidx;
          step_nxt  = '0;
          dlab_nxt  = '0;
          dxy_nxt   = '0;
          state_nxt = S_SQ;
        end else if (clast) begin
          res_nxt.label  = found_r ? bidx_r[9:0] : 10'd0;
          res_nxt.status = found_r ? spsa_pkg::ST_OK : spsa_pkg::ST_NONE;
          state_nxt = S_FIN;
        end else begin
          dc_nxt = (dc_r == LASTC) ? 3'd0 : dc_r + 1'b1;
          dr_nxt = (dc_r == LASTC) ? dr_r + 1'b1 : dr_r;
        end
      end
      S_SQ: begin
        if (step_r < 3'd3) begin
          dlab_nxt = dlab_r + 30'(mul_p);
        end else begin
          dxy_nxt = dxy_r + 33'(mul_p);
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 3'd4) begin
          state_nxt = S_TOT;
        end
      end
      S_TOT: begin
        tot_nxt   = {8'b0, dlab_r, 12'b0} + 50'(mul_p);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (cmp_win) begin
          found_nxt = 1'b1;
          best_nxt  = tot_r;
          bidx_nxt  = cidx_r;
        end
        if (clast) begin
          res_nxt.label  = cmp_win ? cidx_r[9:0] : bidx_r[9:0];
          res_nxt.status = spsa_pkg::ST_OK;
          state_nxt = S_FIN;
        end else begin
          dc_nxt = (dc_r == LASTC) ? 3'd0 : dc_r + 1'b1;
          dr_nxt = (dc_r == LASTC) ? dr_r + 1'b1 : dr_r;
          state_nxt = S_CAND;
        end
      end
      S_ACC: begin
        sm_wa = req_r.seed_index[AW-1:0];
        if (sm_cnt != spsa_pkg::COUNT_MAX) begin
          sm_we = 1'b1;
          sm_wd = {sm_x + SPW'(req_r.pixel_x), sm_y + SPW'(req_r.pixel_y),
                   sm_l + SCW'(req_r.pixel_l), sm_a + SCW'(req_r.pixel_a),
                   sm_b + SCW'(req_r.pixel_b), sm_cnt + 1'b1};
        end
        state_nxt = S_FIN;
      end
      S_MEAN: begin
        if (sm_cnt == '0) begin
          sm_we = 1'b1;
          sm_wa = req_r.seed_index[AW-1:0];
          res_nxt.status     = spsa_pkg::ST_EMPTY;
          res_nxt.seed_x_out = sd_x;
          res_nxt.seed_y_out = sd_y;
          res_nxt.seed_l_out = sd_l;
          res_nxt.seed_a_out = sd_a;
          res_nxt.seed_b_out = sd_b;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DGO;
        end
      end
      S_DGO: begin
        state_nxt = S_DWT;
      end
      S_DWT: begin
        if (div_rsp.done) begin
          mq_nxt[dk_r] = div_rsp.quotient[PW-1:0];
          dk_nxt = dk_r + 1'b1;
          state_nxt = (dk_r == 3'd4) ? S_MWR : S_DGO;
        end
      end
      S_MWR: begin
        sd_we = 1'b1;
        sd_wa = req_r.seed_index[AW-1:0];
        sd_wd = {mq_r[0], mq_r[1], mq_r[2][CHW-1:0], mq_r[3][CHW-1:0], mq_r[4][CHW-1:0]};
        sm_we = 1'b1;
        sm_wa = req_r.seed_index[AW-1:0];
        res_nxt.seed_x_out = mq_r[0];
        res_nxt.seed_y_out = mq_r[1];
        res_nxt.seed_l_out = mq_r[2][CHW-1:0];
        res_nxt.seed_a_out = mq_r[3][CHW-1:0];
        res_nxt.seed_b_out = mq_r[4][CHW-1:0];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          out_nxt   = res_r;
          outv_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      outv_r  <= 1'b0;
      clr_r   <= '0;
      cols_r  <= 6'd16;
      rows_r  <= 6'd16;
      wgt_r   <= 16'd4096;
      found_r <= 1'b0;
      dr_r    <= '0;
      dc_r    <= '0;
      step_r  <= '0;
      dk_r    <= '0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
      clr_r   <= clr_nxt;
      cols_r  <= cols_nxt;
      rows_r  <= rows_nxt;
      wgt_r   <= wgt_nxt;
      found_r <= found_nxt;
      dr_r    <= dr_nxt;
      dc_r    <= dc_nxt;
      step_r  <= step_nxt;
      dk_r    <= dk_nxt;
    end
    req_r  <= req_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    dlab_r <= dlab_nxt;
    dxy_r  <= dxy_nxt;
    tot_r  <= tot_nxt;
    best_r <= best_nxt;
    bidx_r <= bidx_nxt;
    cidx_r <= cidx_nxt;
    for (int i = 0; i < 5; i++) begin
      mq_r[i] <= mq_nxt[i];
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = outv_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // checks
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status != 2'd3))
    else $error("undefined status code");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DWT))
    else $error("divider finished outside its wait state");

  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ready && !out_valid)
    else $error("activity during clearing pass");

endmodule
